FILE: hw/rtl/lrpa_pkg.sv
// Shared constants, types and helper functions of the register pool allocator.
package lrpa_pkg;

	localparam int NUM_REGS   = 16;
	localparam int REG_BITS   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int ID_BITS    = 32;
	localparam int INDEX_BITS = 32;
	localparam int SIZE_BITS  = 16;
	localparam int STACK_BITS = 32;
	localparam int MASK_BITS  = 16;
	localparam logic [MASK_BITS-1:0] MASK_RESET = 16'h0030;

	typedef logic [REG_BITS-1:0]   reg_idx_t;
	typedef logic [NUM_REGS-1:0]   reg_vec_t;
	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [SIZE_BITS-1:0]  size_t;
	typedef logic [STACK_BITS-1:0] stack_t;

	typedef struct packed {
		id_t    id;
		index_t lifetime_end;
		size_t  size;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef enum logic [1:0] {
		PLACE_FREE  = 2'd0,
		PLACE_SPILL = 2'd1,
		PLACE_STACK = 2'd2
	} placement_t;

	// Operands for the shared compare unit.
	typedef struct packed {
		index_t le_lhs;
		index_t le_rhs;
		index_t lt_lhs;
		index_t lt_rhs;
	} cmp_op_t;

	typedef struct packed {
		logic le;
		logic lt;
	} cmp_res_t;

	function automatic id_t to_id(logic [31:0] v);
		logic [ID_BITS+31:0] ext;
		ext = {{ID_BITS{1'b0}}, v};
		return ext[ID_BITS-1:0];
	endfunction

	function automatic index_t to_index(logic [31:0] v);
		logic [INDEX_BITS+31:0] ext;
		ext = {{INDEX_BITS{1'b0}}, v};
		return ext[INDEX_BITS-1:0];
	endfunction

	function automatic logic [31:0] id_to_out(id_t v);
		logic [ID_BITS+31:0] ext;
		ext = {32'b0, v};
		return ext[31:0];
	endfunction

	function automatic logic [3:0] reg_to_out(reg_idx_t v);
		logic [REG_BITS+3:0] ext;
		ext = {4'b0, v};
		return ext[3:0];
	endfunction

	// Registers past the mask width are never reserved.
	function automatic logic reserved_bit(logic [MASK_BITS-1:0] mask, reg_idx_t r);
		logic [MASK_BITS-1:0] sh;
		sh = mask >> r;
		return (32'(r) < MASK_BITS) ? sh[0] : 1'b0;
	endfunction

endpackage

FILE: hw/rtl/lrpa_if.sv
// Request and response channel interfaces of the register pool allocator.
interface lrpa_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_id;
	logic [31:0] value_last_use;
	logic [31:0] now_index;
	logic [15:0] value_size;
	logic        register_eligible;

	modport source (
		output valid, value_id, value_last_use, now_index, value_size, register_eligible,
		input  ready
	);
	modport sink (
		input  valid, value_id, value_last_use, now_index, value_size, register_eligible,
		output ready
	);
endinterface

interface lrpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  placement;
	logic [3:0]  register_index;
	logic [31:0] spilled_id;
	logic [31:0] stack_offset;
	logic        overflow_error;

	modport source (
		output valid, placement, register_index, spilled_id, stack_offset, overflow_error,
		input  ready
	);
	modport sink (
		input  valid, placement, register_index, spilled_id, stack_offset, overflow_error,
		output ready
	);
endinterface

FILE: hw/rtl/lifetime_register_pool_allocator_core.sv
// Top level of the lifetime-driven register pool allocator.
// Places one value per request beat in a register or on the stack. An eligible
// request walks the register entries one per cycle through a single compare
// unit: each step expires the entry if its last use is at or before now_index,
// notes the lowest free unreserved register, and tracks the unreserved held
// entry with the latest last use (lowest index wins a tie). The entry store
// has a registered read, so each scan step fetches the next entry and the last
// step fetches the victim for the decide state. The decide state then picks
// free register, spill or stack and does the single 33-bit stack add.
// req.ready is high only while idle; an eligible request passes through the
// scan state and then decide, an ineligible one goes straight to decide. The
// result sits in an output register, so a new request is taken while the
// previous response still waits; the decide state stalls only if that
// register is still full. A stack addition that would pass 32 bits leaves the
// total alone, reports it as the offset and raises overflow_error.
// reserved_mask (reset 0x0030) is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
module lifetime_register_pool_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	lrpa_req_if.sink    req,
	lrpa_rsp_if.source  rsp
);

	lrpa_pkg::state_t state_q, state_d;

	// Scan bookkeeping
	lrpa_pkg::reg_idx_t scan_q, scan_d;
	lrpa_pkg::reg_vec_t held_q, held_d;
	logic               chosen_vld_q, chosen_vld_d;
	lrpa_pkg::reg_idx_t chosen_q, chosen_d;
	logic               victim_vld_q, victim_vld_d;
	lrpa_pkg::reg_idx_t victim_q, victim_d;
	lrpa_pkg::index_t   vlast_q, vlast_d;

	logic [lrpa_pkg::MASK_BITS-1:0] mask_q;
	lrpa_pkg::stack_t               total_q, total_d;

	// Captured request
	lrpa_pkg::id_t    id_q;
	lrpa_pkg::index_t last_q;
	lrpa_pkg::index_t now_q;
	lrpa_pkg::size_t  size_q;

	// Response register
	logic        rsp_valid_q, rsp_valid_d;
	logic [1:0]  placement_q, placement_d;
	logic [3:0]  reg_out_q, reg_out_d;
	logic [31:0] spilled_q, spilled_d;
	logic [31:0] offset_q, offset_d;
	logic        err_q, err_d;

	// Entry store and compare unit
	lrpa_pkg::reg_idx_t rd_idx;
	lrpa_pkg::entry_t   rd_entry;
	logic               wr_en;
	lrpa_pkg::reg_idx_t wr_idx;
	lrpa_pkg::entry_t   wr_entry;
	lrpa_pkg::cmp_op_t  cmp_op;
	lrpa_pkg::cmp_res_t cmp_res;

	logic                        accept;
	logic                        go;
	logic                        hit, held_eff, rsv;
	logic                        do_free, do_spill, do_stack;
	lrpa_pkg::size_t             add_size;
	logic [lrpa_pkg::STACK_BITS:0] sum;

	lrpa_entry_file #(
		.WIDTH ($bits(lrpa_pkg::entry_t)),
		.DEPTH (lrpa_pkg::NUM_REGS)
	) u_entries (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.raddr (rd_idx),
		.rdata (rd_entry)
	);

	lrpa_cmp_unit u_cmp (
		.op  (cmp_op),
		.res (cmp_res)
	);

	assign req.ready = (state_q == lrpa_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	// Output register free to take a new result
	assign go        = !rsp_valid_q || rsp.ready;

	assign wr_entry.id           = id_q;
	assign wr_entry.lifetime_end = last_q;
	assign wr_entry.size         = size_q;

	always_comb begin
		// Scan: expiry and victim tests; decide: does the victim outlive the request
		cmp_op.le_lhs = rd_entry.lifetime_end;
		cmp_op.le_rhs = now_q;
		if (state_q == lrpa_pkg::ST_DECIDE) begin
			cmp_op.lt_lhs = last_q;
			cmp_op.lt_rhs = vlast_q;
		end else begin
			cmp_op.lt_lhs = vlast_q;
			cmp_op.lt_rhs = rd_entry.lifetime_end;
		end
	end

	always_comb begin
		hit      = held_q[scan_q];
		held_eff = hit && !cmp_res.le;
		rsv      = lrpa_pkg::reserved_bit(mask_q, scan_q);

		do_free  = chosen_vld_q;
		do_spill = !chosen_vld_q && victim_vld_q && cmp_res.lt;
		do_stack = !do_free && !do_spill;
		add_size = do_spill ? rd_entry.size : size_q;
		sum      = {1'b0, total_q} + {{(lrpa_pkg::STACK_BITS + 1 - lrpa_pkg::SIZE_BITS){1'b0}},
			add_size};

		state_d      = state_q;
		scan_d       = scan_q;
		held_d       = held_q;
		chosen_vld_d = chosen_vld_q;
		chosen_d     = chosen_q;
		victim_vld_d = victim_vld_q;
		victim_d     = victim_q;
		vlast_d      = vlast_q;
		total_d      = total_q;
		wr_en        = 1'b0;
		wr_idx       = do_free ? chosen_q : victim_q;

		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		placement_d  = placement_q;
		reg_out_d    = reg_out_q;
		spilled_d    = spilled_q;
		offset_d     = offset_q;
		err_d        = err_q;

		unique case (state_q)
			lrpa_pkg::ST_IDLE: begin
				if (accept) begin
					scan_d       = '0;
					chosen_vld_d = 1'b0;
					victim_vld_d = 1'b0;
					state_d      = req.register_eligible ? lrpa_pkg::ST_SCAN
						: lrpa_pkg::ST_DECIDE;
				end
			end
			lrpa_pkg::ST_SCAN: begin
				held_d[scan_q] = held_eff;
				if (!held_eff && !rsv && !chosen_vld_q) begin
					chosen_vld_d = 1'b1;
					chosen_d     = scan_q;
				end
				if (held_eff && !rsv && (!victim_vld_q || cmp_res.lt)) begin
					victim_vld_d = 1'b1;
					victim_d     = scan_q;
					vlast_d      = rd_entry.lifetime_end;
				end
				scan_d = scan_q + 1'b1;
				if (scan_q == lrpa_pkg::REG_BITS'(lrpa_pkg::NUM_REGS - 1)) begin
					state_d = lrpa_pkg::ST_DECIDE;
				end
			end
			lrpa_pkg::ST_DECIDE: begin
				if (go) begin
					state_d     = lrpa_pkg::ST_IDLE;
					rsp_valid_d = 1'b1;
					spilled_d   = '0;
					offset_d    = '0;
					err_d       = 1'b0;
					reg_out_d   = '0;
					if (do_free || do_spill) begin
						wr_en          = 1'b1;
						held_d[wr_idx] = 1'b1;
						reg_out_d      = lrpa_pkg::reg_to_out(wr_idx);
					end
					if (do_spill || do_stack) begin
						// Overflow holds the total and reports it unchanged
						err_d = sum[lrpa_pkg::STACK_BITS];
						if (!sum[lrpa_pkg::STACK_BITS]) begin
							total_d = sum[lrpa_pkg::STACK_BITS-1:0];
						end
						offset_d = sum[lrpa_pkg::STACK_BITS] ? total_q
							: sum[lrpa_pkg::STACK_BITS-1:0];
					end
					if (do_spill) begin
						spilled_d = lrpa_pkg::id_to_out(rd_entry.id);
					end
					priority if (do_free) begin
						placement_d = lrpa_pkg::PLACE_FREE;
					end else if (do_spill) begin
						placement_d = lrpa_pkg::PLACE_SPILL;
					end else begin
						placement_d = lrpa_pkg::PLACE_STACK;
					end
				end
			end
			default: begin
				state_d = lrpa_pkg::ST_IDLE;
			end
		endcase
	end

	// Read address for next cycle's entry: idle prefetches entry 0, the scan
	// fetches one ahead and its last step the victim, decide holds the victim.
	always_comb begin
		unique case (state_q)
			lrpa_pkg::ST_SCAN: begin
				if (scan_q == lrpa_pkg::REG_BITS'(lrpa_pkg::NUM_REGS - 1)) begin
					rd_idx = victim_d;
				end else begin
					rd_idx = scan_q + 1'b1;
				end
			end
			lrpa_pkg::ST_DECIDE: begin
				rd_idx = victim_q;
			end
			default: begin
				rd_idx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			held_q       <= '0;
			chosen_vld_q <= 1'b0;
			victim_vld_q <= 1'b0;
			mask_q       <= lrpa_pkg::MASK_RESET;
			total_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			scan_q       <= scan_d;
			held_q       <= held_d;
			chosen_vld_q <= chosen_vld_d;
			victim_vld_q <= victim_vld_d;
			total_q      <= total_d;
			rsp_valid_q  <= rsp_valid_d;
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		chosen_q    <= chosen_d;
		victim_q    <= victim_d;
		vlast_q     <= vlast_d;
		placement_q <= placement_d;
		reg_out_q   <= reg_out_d;
		spilled_q   <= spilled_d;
		offset_q    <= offset_d;
		err_q       <= err_d;
		if (accept) begin
			id_q   <= lrpa_pkg::to_id(req.value_id);
			last_q <= lrpa_pkg::to_index(req.value_last_use);
			now_q  <= lrpa_pkg::to_index(req.now_index);
			size_q <= req.value_size;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.placement      = placement_q;
	assign rsp.register_index = reg_out_q;
	assign rsp.spilled_id     = spilled_q;
	assign rsp.stack_offset   = offset_q;
	assign rsp.overflow_error = err_q;

endmodule

FILE: hw/rtl/lrpa_cmp_unit.sv
// Shared compare unit: expiry test and latest-last-use test.
module lrpa_cmp_unit (
	input  lrpa_pkg::cmp_op_t  op,
	output lrpa_pkg::cmp_res_t res
);

	assign res.le = (op.le_lhs <= op.le_rhs);
	assign res.lt = (op.lt_lhs <  op.lt_rhs);

endmodule

FILE: hw/rtl/lrpa_entry_file.sv
// Generic RAM: one write port, one read port with registered read data.
module lrpa_entry_file #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lrpa_checker.sv
// Port-level checker for the register pool allocator, bound to the top level.
module lrpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  placement,
	input logic [3:0]  register_index,
	input logic [31:0] spilled_id,
	input logic [31:0] stack_offset,
	input logic        overflow_error
);

	// Busy in the cycle after taking a request beat
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response beat dropped before taken");

	a_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && placement == lrpa_pkg::PLACE_FREE) |->
		(spilled_id == 32'd0 && stack_offset == 32'd0 && !overflow_error))
		else $error("free placement with stack fields set");

	a_stack_no_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && placement == lrpa_pkg::PLACE_STACK) |->
		(register_index == 4'd0 && spilled_id == 32'd0))
		else $error("stack placement carries register fields");

	a_placement_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (placement == lrpa_pkg::PLACE_FREE ||
			placement == lrpa_pkg::PLACE_SPILL || placement == lrpa_pkg::PLACE_STACK))
		else $error("undefined placement code");

endmodule

bind lifetime_register_pool_allocator_core lrpa_checker u_lrpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.placement      (rsp.placement),
	.register_index (rsp.register_index),
	.spilled_id     (rsp.spilled_id),
	.stack_offset   (rsp.stack_offset),
	.overflow_error (rsp.overflow_error)
);

FILE: sim/lifetime_register_pool_allocator_core_test.sv
// Self-checking testbench of the register pool allocator: directed table, random programs.
module lifetime_register_pool_allocator_core_test;

	// Run limit. The slowest correct run is about 630 requests, each with its
	// block time plus a random stall on either side, plus the pauses around
	// the mask writes.
	localparam int LIMIT    = 200_000;
	// Idle pause before a mask write and at the end.
	localparam int SETTLE   = 24;
	localparam int PER_MASK = 86;   // random requests per mask setting

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] lifetime_end;
		logic [31:0] now;
		logic [15:0] size;
		logic        eligible;
	} request_t;

	typedef struct packed {
		lrpa_pkg::placement_t placement;
		logic [3:0]           reg_index;
		logic [31:0]          spilled_id;
		logic [31:0]          offset;
		logic                 overflow;
	} placement_rec_t;

	typedef struct packed {
		request_t       rq;
		logic           typed;   // 1: use the hand-written result below
		placement_rec_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	lrpa_req_if req ();
	lrpa_rsp_if rsp ();

	lifetime_register_pool_allocator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Allocator state as the testbench sees it.
	logic [lrpa_pkg::MASK_BITS-1:0] reserved_regs = lrpa_pkg::MASK_RESET;
	lrpa_pkg::reg_vec_t             held_regs = '0;
	lrpa_pkg::entry_t               entries [lrpa_pkg::NUM_REGS];
	lrpa_pkg::stack_t               stack_used = '0;

	placement_rec_t placements_due [$];
	int             failures = 0;
	int             cycles = 0;
	bit             no_gaps = 1'b0;   // both sides run without idling
	logic [31:0]    program_pos = 32'd0;

	// Directed table. Reset state: registers 4 and 5 reserved, stack empty.
	// Rows 1..14 fill all 14 free registers; row 15 spills the max-lifetime
	// entry in register 1; later rows hit stack fallback, expiry at the
	// boundary and at the top of the index range, and zero sizes.
	directed_row_t directed [22] = '{
		'{'{32'h0,        32'h0,        32'h0,        16'h0010, 1'b0}, 1'b1,
			'{lrpa_pkg::PLACE_STACK, 4'd0, 32'h0, 32'h10, 1'b0}},
		'{'{32'h11,       32'd100,      32'h0,        16'h0008, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_FREE, 4'd0, 32'h0, 32'h0, 1'b0}},
		'{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        16'hFFFF, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_FREE, 4'd1, 32'h0, 32'h0, 1'b0}},
		'{'{32'h13,       32'd200,      32'd1,        16'h0004, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_FREE, 4'd2, 32'h0, 32'h0, 1'b0}},
		'{'{32'h14,       32'd300,      32'd1,        16'h0004, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_FREE, 4'd3, 32'h0, 32'h0, 1'b0}},
		// skips the reserved stack and frame pointer registers
		'{'{32'h15,       32'd400,      32'd2,        16'h0004, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_FREE, 4'd6, 32'h0, 32'h0, 1'b0}},
		'{'{32'h16,       32'd500,      32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h17,       32'd600,      32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h18,       32'd700,      32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h19,       32'd800,      32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h1A,       32'd900,      32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h1B,       32'd1000,     32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h1C,       32'd1100,     32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h1D,       32'd1200,     32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		'{'{32'h1E,       32'd1300,     32'd2,        16'h000C, 1'b1}, 1'b0, '0},
		// pool full: register 1 outlives everything, gets spilled
		'{'{32'h21,       32'd50,       32'd3,        16'h0020, 1'b1}, 1'b1,
			'{lrpa_pkg::PLACE_SPILL, 4'd1, 32'hFFFFFFFF, 32'h1000F, 1'b0}},
		// longest-lived request: nothing outlives it, goes to the stack
		'{'{32'h22,       32'hFFFFFFFF, 32'd3,        16'h0040, 1'b1}, 1'b0, '0},
		// equal to the latest last use: no spill either
		'{'{32'h23,       32'd1300,     32'd3,        16'h0080, 1'b1}, 1'b0, '0},
		// last use equal to now expires register 0
		'{'{32'h24,       32'd10,       32'd100,      16'h0002, 1'b1}, 1'b0, '0},
		'{'{32'h25,       32'h0,        32'hFFFFFFFF, 16'h0003, 1'b1}, 1'b0, '0},
		'{'{32'h26,       32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0}, 1'b0, '0},
		'{'{32'h0,        32'h0,        32'h0,        16'h0000, 1'b1}, 1'b0, '0}
	};

	// Returns 1 on overflow, in which case the total is left alone.
	function automatic logic grow_stack(lrpa_pkg::size_t amount);
		logic [32:0] sum;
		sum = {1'b0, stack_used} + {17'b0, amount};
		if (!sum[32])
			stack_used = sum[31:0];
		return sum[32];
	endfunction

	function automatic placement_rec_t place_value(request_t r);
		placement_rec_t res;
		int i;
		int pick;
		int victim;
		res = '{lrpa_pkg::PLACE_STACK, 4'd0, 32'd0, 32'd0, 1'b0};
		pick = -1;
		victim = -1;
		if (r.eligible) begin
			for (i = 0; i < lrpa_pkg::NUM_REGS; i++)
				if (held_regs[i] && entries[i].lifetime_end <= r.now)
					held_regs[i] = 1'b0;
			for (i = 0; i < lrpa_pkg::NUM_REGS && pick < 0; i++)
				if (!held_regs[i] && !reserved_regs[i])
					pick = i;
			if (pick >= 0) begin
				res.placement = lrpa_pkg::PLACE_FREE;
			end else begin
				// latest last use among held, unreserved entries; lowest index on a tie
				for (i = 0; i < lrpa_pkg::NUM_REGS; i++)
					if (held_regs[i] && !reserved_regs[i] &&
					    (victim < 0 ||
					     entries[victim].lifetime_end < entries[i].lifetime_end))
						victim = i;
				if (victim >= 0 && entries[victim].lifetime_end > r.lifetime_end) begin
					pick = victim;
					res.placement = lrpa_pkg::PLACE_SPILL;
					res.spilled_id = entries[victim].id;
					res.overflow = grow_stack(entries[victim].size);
					res.offset = stack_used;
				end
			end
			if (pick >= 0) begin
				held_regs[pick] = 1'b1;
				entries[pick] = '{r.id, r.lifetime_end, r.size};
				res.reg_index = 4'(pick);
			end
		end
		if (res.placement == lrpa_pkg::PLACE_STACK) begin
			res.overflow = grow_stack(r.size);
			res.offset = stack_used;
		end
		return res;
	endfunction

	// Mostly a linear program: now creeps forward, last uses land a little
	// ahead, so the pool fills, spills and expires. A tenth is pure noise.
	function automatic request_t draw_request();
		request_t r;
		r.id = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			r.lifetime_end = $urandom;
			r.now = $urandom;
			r.size = 16'($urandom);
			r.eligible = 1'($urandom_range(0, 1));
		end else begin
			if ($urandom_range(0, 49) == 0)
				program_pos = $urandom;   // rebase, may wrap near the top
			r.now = program_pos;
			program_pos += $urandom_range(0, 2);
			r.lifetime_end = r.now + $urandom_range(0, 48);
			r.size = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
			r.eligible = ($urandom_range(0, 4) != 0);
		end
		return r;
	endfunction

	// Called and returns at a falling edge. Predicts at the accepting edge.
	task automatic push_request(request_t r, logic typed, placement_rec_t typed_want);
		int gap;
		placement_rec_t pred;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.value_id <= r.id;
		req.value_last_use <= r.lifetime_end;
		req.now_index <= r.now;
		req.value_size <= r.size;
		req.register_eligible <= r.eligible;
		do
			@(posedge clk);
		while (!(req.valid === 1'b1 && req.ready === 1'b1));
		pred = place_value(r);
		placements_due.push_back(typed ? typed_want : pred);
		@(negedge clk);
	endtask

	// Wait for all outstanding beats, then let the block go quiet.
	task automatic settle();
		req.valid <= 1'b0;
		while (placements_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mask(logic [15:0] mask);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= mask;
		@(negedge clk);
		cfg_we <= 1'b0;
		reserved_regs = mask;
	endtask

	// Response side: random stall before each beat, none while no_gaps holds.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1));
		end
	end

	// Scoreboard: each response beat against the oldest prediction.
	always @(posedge clk) begin
		placement_rec_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (placements_due.size() == 0) begin
				$error("unexpected response beat, placement %0d", rsp.placement);
				failures++;
			end else begin
				want = placements_due.pop_front();
				if (rsp.placement !== want.placement) begin
					$error("placement expected %0d actual %0d", want.placement, rsp.placement);
					failures++;
				end
				if (rsp.register_index !== want.reg_index) begin
					$error("register_index expected %0d actual %0d",
						want.reg_index, rsp.register_index);
					failures++;
				end
				if (rsp.spilled_id !== want.spilled_id) begin
					$error("spilled_id expected %h actual %h", want.spilled_id, rsp.spilled_id);
					failures++;
				end
				if (rsp.stack_offset !== want.offset) begin
					$error("stack_offset expected %h actual %h", want.offset, rsp.stack_offset);
					failures++;
				end
				if (rsp.overflow_error !== want.overflow) begin
					$error("overflow_error expected %0d actual %0d",
						want.overflow, rsp.overflow_error);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		int k;
		logic [15:0] phase_masks [7];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.value_id = '0;
		req.value_last_use = '0;
		req.now_index = '0;
		req.value_size = '0;
		req.register_eligible = 1'b0;
		// all reserved (no spill candidate), none, a held set turned reserved,
		// one register only, the two ends, random, back to reset value
		phase_masks = '{16'hFFFF, 16'h0000, 16'h00FF, 16'hFFFE, 16'h7FFE,
			16'($urandom), lrpa_pkg::MASK_RESET};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < 22; i++)
			push_request(directed[i].rq, directed[i].typed, directed[i].want);

		for (p = 0; p < 7; p++) begin
			write_mask(phase_masks[p]);
			for (k = 0; k < PER_MASK; k++) begin
				if ($urandom_range(0, 24) == 0)
					no_gaps = !no_gaps;
				push_request(draw_request(), 1'b0, '0);
			end
		end
		no_gaps = 1'b0;

		settle();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
